>>> rtl/kmeq_pkg.sv
// Shared types, constants and helper function of the key matrix event queue.
package kmeq_pkg;

    localparam int unsigned ROW_LINES_W     = 9;
    localparam int unsigned COL_LINES_W     = 8;
    localparam int unsigned ROW_IDX_W       = 4;
    localparam int unsigned COL_IDX_W       = 3;
    localparam int unsigned CNT_W           = 5;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned ROW_COUNT_DEF   = 9;
    localparam int unsigned COL_COUNT_DEF   = 8;

    // Request kinds
    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Event kinds
    localparam logic EVT_UP   = 1'b0;
    localparam logic EVT_DOWN = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [ROW_LINES_W-1:0] row_lines;
        logic [COL_LINES_W-1:0] col_lines;
    } t_scan_req;

    typedef struct packed {
        logic                 event_valid;
        logic [ROW_IDX_W-1:0] event_row;
        logic [COL_IDX_W-1:0] event_col;
        logic                 event_down;
        logic                 dropped;
        logic [CNT_W-1:0]     queued_count;
    } t_event_rsp;

    // One queue entry
    typedef struct packed {
        logic [ROW_IDX_W-1:0] row;
        logic [COL_IDX_W-1:0] col;
        logic                 down;
    } t_event;

    typedef struct packed {
        logic                 ok;
        logic [ROW_IDX_W-1:0] idx;
    } t_pick;

    // Highest set bit below lim, or none.
    function automatic t_pick pick_highest(input logic [ROW_LINES_W-1:0] bits,
                                           input int unsigned lim);
        t_pick res;
        res = '0;
        for (int unsigned i = 0; i < ROW_LINES_W; i++) begin
            if (i < lim && bits[i]) begin
                res.ok  = 1'b1;
                res.idx = ROW_IDX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/kmeq_if.sv
// Valid/ready channels of the key matrix event queue.
interface kmeq_scan_if;
    kmeq_pkg::t_scan_req payload;
    logic                valid;
    logic                ready;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface kmeq_event_if;
    kmeq_pkg::t_event_rsp payload;
    logic                 valid;
    logic                 ready;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/kmeq_store.sv
// Event ring storage: one write port, one read port with registered read data.
module kmeq_store #(
    parameter int unsigned QUEUE_DEPTH = kmeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_wr_addr,
    input  kmeq_pkg::t_event               i_wr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_rd_addr,
    output kmeq_pkg::t_event               o_rd_data
);
    import kmeq_pkg::*;

    t_event r_mem [QUEUE_DEPTH];
    t_event r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/key_matrix_event_queue.sv
// Key matrix event queue: top level.
// A scan request writes its key-up or key-down at once; a key-down queued with a key-up is
// deferred to a second write (the event store has a single write port). Its response is
// registered in the cycle after acceptance. A pop reads the event store into its read data
// register, then loads the response from it. Up to one request per cycle, while nothing is
// deferred and the response drains. Synchronous active-low reset clears pointers, count and flags.
module key_matrix_event_queue #(
    parameter int unsigned QUEUE_DEPTH = kmeq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned ROW_COUNT   = kmeq_pkg::ROW_COUNT_DEF,
    parameter int unsigned COL_COUNT   = kmeq_pkg::COL_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kmeq_scan_if.sink    i_scan,
    kmeq_event_if.source o_event
);
    import kmeq_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned RLIM  = (ROW_COUNT < ROW_LINES_W) ? ROW_COUNT : ROW_LINES_W;
    localparam int unsigned CLIM  = (COL_COUNT < COL_LINES_W) ? COL_COUNT : COL_LINES_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
    localparam logic [OCC_W-1:0] OCC_NEAR = OCC_W'(QUEUE_DEPTH - 1);

    // Queue pointers and occupancy
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [OCC_W-1:0] r_occ,    n_occ;

    // Previously seen key (row and column tracked separately)
    logic                 r_last_row_ok, n_last_row_ok;
    logic                 r_last_col_ok, n_last_col_ok;
    logic [ROW_IDX_W-1:0] r_last_row,    n_last_row;
    logic [COL_IDX_W-1:0] r_last_col,    n_last_col;

    // Deferred work: a deferred key-down write, or a pop waiting on read data
    logic       r_pend_wr,  n_pend_wr;
    t_event     r_pend_evt, n_pend_evt;
    logic       r_pend_pop, n_pend_pop;
    logic [CNT_W-1:0] r_pend_cnt, n_pend_cnt;

    // Response register
    logic       r_out_valid, n_out_valid;
    t_event_rsp r_out,       n_out;

    // Store port signals
    logic       wr_en;
    logic [PTR_W-1:0] wr_addr;
    t_event     wr_data;
    logic       rd_en;
    t_event     rd_data;

    // Scan decode
    t_pick      row_pick, col_pick;
    logic       accept, busy, is_pop;
    logic       changed, up_req, dn_req, up_ok, dn_ok;
    t_event     up_evt, dn_evt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    kmeq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    // Hold new requests while deferred work is open or the response slot stays full.
    assign busy           = r_pend_wr || r_pend_pop;
    assign i_scan.ready   = !busy && (!r_out_valid || o_event.ready);
    assign accept         = i_scan.valid && i_scan.ready;
    assign is_pop         = (i_scan.payload.mode == MODE_POP);

    assign o_event.valid   = r_out_valid;
    assign o_event.payload = r_out;

    // Highest active row; columns are active low, so invert before searching.
    assign row_pick = pick_highest(i_scan.payload.row_lines, RLIM);
    assign col_pick = pick_highest({1'b0, ~i_scan.payload.col_lines}, CLIM);

    // A key change is any difference in presence, or in index where present.
    assign changed = (row_pick.ok != r_last_row_ok) || (col_pick.ok != r_last_col_ok)
                  || (row_pick.ok && (row_pick.idx != r_last_row))
                  || (col_pick.ok && (COL_IDX_W'(col_pick.idx) != r_last_col));
    assign up_req  = changed && r_last_row_ok && r_last_col_ok;
    assign dn_req  = changed && row_pick.ok && col_pick.ok;
    // Drop an event that finds the queue full; the key-down sees the key-up's slot.
    assign up_ok   = up_req && (r_occ < OCC_FULL);
    assign dn_ok   = dn_req && (up_ok ? (r_occ < OCC_NEAR) : (r_occ < OCC_FULL));

    assign up_evt  = '{row: r_last_row, col: r_last_col, down: EVT_UP};
    assign dn_evt  = '{row: row_pick.idx, col: COL_IDX_W'(col_pick.idx), down: EVT_DOWN};

    always_comb begin
        n_rd_ptr      = r_rd_ptr;
        n_wr_ptr      = r_wr_ptr;
        n_occ         = r_occ;
        n_last_row_ok = r_last_row_ok;
        n_last_col_ok = r_last_col_ok;
        n_last_row    = r_last_row;
        n_last_col    = r_last_col;
        n_pend_wr     = 1'b0;
        n_pend_evt    = r_pend_evt;
        n_pend_pop    = 1'b0;
        n_pend_cnt    = r_pend_cnt;
        n_out_valid   = r_out_valid && !o_event.ready;
        n_out         = r_out;
        wr_en         = 1'b0;
        wr_addr       = r_wr_ptr;
        wr_data       = dn_evt;
        rd_en         = 1'b0;

        // Finish a pop: read data is back from the store.
        if (r_pend_pop) begin
            n_out_valid        = 1'b1;
            n_out              = '0;
            n_out.event_valid  = 1'b1;
            n_out.event_row    = rd_data.row;
            n_out.event_col    = rd_data.col;
            n_out.event_down   = rd_data.down;
            n_out.queued_count = r_pend_cnt;
        end

        // Write the deferred key-down in the slot after the key-up.
        if (r_pend_wr) begin
            wr_en    = 1'b1;
            wr_data  = r_pend_evt;
            n_wr_ptr = ptr_inc(r_wr_ptr);
        end

        if (accept) begin
            if (is_pop) begin
                if (r_occ != '0) begin
                    // Issue the read now; the response is loaded from the read data once it returns.
                    rd_en      = 1'b1;
                    n_rd_ptr   = ptr_inc(r_rd_ptr);
                    n_occ      = r_occ - OCC_W'(1);
                    n_pend_pop = 1'b1;
                    n_pend_cnt = CNT_W'(n_occ);
                end else begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                end
            end else begin
                if (up_ok) begin
                    wr_en    = 1'b1;
                    wr_data  = up_evt;
                    n_wr_ptr = ptr_inc(r_wr_ptr);
                    if (dn_ok) begin
                        n_pend_wr  = 1'b1;
                        n_pend_evt = dn_evt;
                    end
                end else if (dn_ok) begin
                    wr_en    = 1'b1;
                    wr_data  = dn_evt;
                    n_wr_ptr = ptr_inc(r_wr_ptr);
                end
                n_occ = r_occ + OCC_W'(up_ok) + OCC_W'(dn_ok);
                if (changed) begin
                    n_last_row_ok = row_pick.ok;
                    n_last_col_ok = col_pick.ok;
                    n_last_row    = row_pick.idx;
                    n_last_col    = COL_IDX_W'(col_pick.idx);
                end
                // Scan response is complete now, even with a key-down still to write.
                n_out_valid        = 1'b1;
                n_out              = '0;
                n_out.dropped      = (up_req && !up_ok) || (dn_req && !dn_ok);
                n_out.queued_count = CNT_W'(n_occ);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr      <= '0;
            r_wr_ptr      <= '0;
            r_occ         <= '0;
            r_last_row_ok <= 1'b0;
            r_last_col_ok <= 1'b0;
            r_last_row    <= '1;
            r_last_col    <= '1;
            r_pend_wr     <= 1'b0;
            r_pend_pop    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_rd_ptr      <= n_rd_ptr;
            r_wr_ptr      <= n_wr_ptr;
            r_occ         <= n_occ;
            r_last_row_ok <= n_last_row_ok;
            r_last_col_ok <= n_last_col_ok;
            r_last_row    <= n_last_row;
            r_last_col    <= n_last_col;
            r_pend_wr     <= n_pend_wr;
            r_pend_pop    <= n_pend_pop;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_evt <= n_pend_evt;
        r_pend_cnt <= n_pend_cnt;
        r_out      <= n_out;
    end

endmodule
